// ===== design/fdss_pkg.sv =====
package fdss_pkg;

    typedef enum logic [2:0] {
        OP_TICK    = 3'd0,
        OP_CLEAR   = 3'd1,
        OP_NUMBER  = 3'd2,
        OP_PROGRAM = 3'd3,
        OP_RUNNING = 3'd4
    } t_op;

    typedef logic [7:0] t_code;
    typedef t_code [3:0] t_codes;

    // number after sign handling, split by thousands
    typedef struct packed {
        logic       neg;
        logic [5:0] thousands;
        logic [9:0] rest;
    } t_split;

    localparam t_code GLYPH_P      = 8'd10;
    localparam t_code GLYPH_BLANK  = 8'd11;
    localparam t_code GLYPH_RUN3   = 8'd12;
    localparam t_code GLYPH_RUN2   = 8'd13;
    localparam t_code GLYPH_RUN1   = 8'd14;
    localparam t_code GLYPH_MINUS  = 8'd18;

    localparam logic [15:0] NEG_CLAMP = 16'd999;

    // active-low patterns, bit 7 unused, codes past the table show blank
    function automatic logic [7:0] glyph_pattern(input t_code code);
        logic [7:0] pat;
        case (code)
            8'd0:    pat = 8'hC0;
            8'd1:    pat = 8'hF9;
            8'd2:    pat = 8'hA4;
            8'd3:    pat = 8'hB0;
            8'd4:    pat = 8'h99;
            8'd5:    pat = 8'h92;
            8'd6:    pat = 8'h82;
            8'd7:    pat = 8'hF8;
            8'd8:    pat = 8'h80;
            8'd9:    pat = 8'h90;
            8'd10:   pat = 8'h0C;
            8'd11:   pat = 8'hFF;
            8'd12:   pat = 8'h88;
            8'd13:   pat = 8'hC1;
            8'd14:   pat = 8'hC8;
            8'd15:   pat = 8'hAF;
            8'd16:   pat = 8'hE3;
            8'd17:   pat = 8'hAB;
            8'd18:   pat = 8'hBF;
            default: pat = 8'hFF;
        endcase
        return pat;
    endfunction

endpackage

// ===== design/fdss_if.sv =====
interface fdss_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         operation;
    logic signed [15:0] number_value;
    logic [7:0]         program_index;

    modport source (output valid, output operation, output number_value,
                    output program_index, input ready);
    modport sink   (input valid, input operation, input number_value,
                    input program_index, output ready);
endinterface

interface fdss_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] digit_position;
    logic [3:0] common_drive;
    logic [6:0] segment_drive;
    logic       bottom_drive;

    modport source (output valid, output digit_position, output common_drive,
                    output segment_drive, output bottom_drive, input ready);
    modport sink   (input valid, input digit_position, input common_drive,
                    input segment_drive, input bottom_drive, output ready);
endinterface

// ===== design/fdss_num_split.sv =====
module fdss_num_split
    import fdss_pkg::*;
(
    input  t_split i_split,
    output t_codes o_codes
);

    logic [17:0] w_p10;
    logic [15:0] w_p100;
    logic [6:0]  w_tens_all;
    logic [3:0]  w_d0;
    logic [3:0]  w_d1;
    logic [3:0]  w_d2;
    logic        w_has_k;
    logic        w_show2;
    logic        w_show1;

    // rest < 1000: reciprocal multiplies for /10 and /100
    assign w_p10      = {8'd0, i_split.rest} * 18'd205;
    assign w_p100     = {6'd0, i_split.rest} * 16'd41;
    assign w_tens_all = w_p10[17:11];
    assign w_d2       = w_p100[15:12];
    assign w_d0       = 4'(i_split.rest - 10'(w_tens_all) * 10'd10);
    assign w_d1       = 4'(w_tens_all - 7'(w_d2) * 7'd10);

    // leading zero blanking
    assign w_has_k  = (i_split.thousands != 6'd0);
    assign w_show2  = w_has_k || (i_split.rest > 10'd99);
    assign w_show1  = w_show2 || (w_d1 != 4'd0);

    always_comb begin
        if (i_split.neg) begin
            o_codes[3] = GLYPH_MINUS;
        end else if (w_has_k) begin
            o_codes[3] = {2'b00, i_split.thousands};
        end else begin
            o_codes[3] = GLYPH_BLANK;
        end
        o_codes[2] = w_show2 ? {4'd0, w_d2} : GLYPH_BLANK;
        o_codes[1] = w_show1 ? {4'd0, w_d1} : GLYPH_BLANK;
        o_codes[0] = {4'd0, w_d0};
    end

endmodule

// ===== design/four_digit_seven_segment_scanner_top.sv =====
// Four-digit multiplexed seven-segment driver. Each input transaction is
// either a scan tick or an update of the four glyph codes (clear, signed
// number, program index shown as 'P' and the index, or the running marker
// with the index). Only scan ticks produce an output transaction: the next
// digit position (wrapping 3 to 0, so the first tick after reset drives
// digit 1), the active-low common for that digit, its active-low segment
// pattern and the shared bottom-bar line (0 = lit). Numbers below zero show
// a minus sign with the magnitude clamped to 999; positive numbers of 10000
// and above put the thousands count as a glyph code on the left digit,
// where codes of 19 and above are blank. The block takes one transaction
// per cycle while no result waits to be taken; a scan tick's result passes
// through the input, digit split and result registers in that order.
// The three stages move together, so the whole pipeline holds
// while a result waits to be taken, and input ready drops only in that case.
module four_digit_seven_segment_scanner_top
    import fdss_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    fdss_in_if.sink    i_in,
    fdss_out_if.source o_out
);

    // pipeline advance: result register empty or being taken
    logic w_en;

    // stage 1: captured transaction
    logic               r_s1_valid;
    t_op                r_s1_op;
    logic signed [15:0] r_s1_value;
    logic [7:0]         r_s1_idx;

    // stage 2: number split by thousands
    logic   r_s2_valid;
    t_op    r_s2_op;
    logic [7:0] r_s2_idx;
    t_split r_s2_split;

    // display state
    t_codes     r_codes;
    t_codes     n_codes;
    logic [1:0] r_pos;
    logic [1:0] n_pos;

    // result register
    logic       r_out_valid;
    logic       n_out_valid;
    logic [1:0] r_out_pos;
    logic [3:0] r_out_common;
    logic [6:0] r_out_seg;
    logic       r_out_bottom;
    logic [1:0] n_out_pos;
    logic [3:0] n_out_common;
    logic [6:0] n_out_seg;
    logic       n_out_bottom;

    // stage 1 to 2 logic
    logic        w_neg;
    logic [15:0] w_neg_mag;
    logic [14:0] w_mag;
    logic [30:0] w_prod;
    logic [5:0]  w_k;
    t_split      n_split;

    t_codes     w_num_codes;
    logic [7:0] w_pat;

    assign w_en       = !r_out_valid || o_out.ready;
    assign i_in.ready = w_en;

    // --- stage 1 ---
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_en) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_op    <= t_op'(i_in.operation);
            r_s1_value <= i_in.number_value;
            r_s1_idx   <= i_in.program_index;
        end
    end

    // --- magnitude with clamp, then thousands by reciprocal multiply ---
    always_comb begin
        w_neg     = r_s1_value[15];
        w_neg_mag = 16'(~r_s1_value + 16'sd1);  // -32768 gives 32768, clamped below
        if (w_neg) begin
            w_mag = (w_neg_mag > NEG_CLAMP) ? 15'(NEG_CLAMP) : w_neg_mag[14:0];
        end else begin
            w_mag = r_s1_value[14:0];
        end
        // 33555 / 2^25 approximates 1/1000, exact for magnitudes below 32768
        w_prod = {16'd0, w_mag} * 31'd33555;
        w_k    = w_prod[30:25];
        n_split.neg       = w_neg;
        n_split.thousands = w_k;
        n_split.rest      = 10'(w_mag - 15'(w_k) * 15'd1000);
    end

    // --- stage 2 ---
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_en) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_op    <= r_s1_op;
            r_s2_idx   <= r_s1_idx;
            r_s2_split <= n_split;
        end
    end

    fdss_num_split u_split (
        .i_split (r_s2_split),
        .o_codes (w_num_codes)
    );

    // --- apply: update glyph codes or scan one digit ---
    always_comb begin
        n_codes      = r_codes;
        n_pos        = r_pos;
        n_out_valid  = 1'b0;
        n_out_pos    = r_out_pos;
        n_out_common = r_out_common;
        n_out_seg    = r_out_seg;
        n_out_bottom = r_out_bottom;
        w_pat        = 8'hFF;
        if (r_s2_valid) begin
            case (r_s2_op)
                OP_TICK: begin
                    n_pos        = 2'(r_pos + 2'd1);
                    w_pat        = glyph_pattern(r_codes[n_pos]);
                    n_out_valid  = 1'b1;
                    n_out_pos    = n_pos;
                    n_out_common = 4'hF & ~(4'b0001 << n_pos);
                    n_out_seg    = w_pat[6:0];
                    // bottom segment lit means pattern bit 3 low
                    n_out_bottom = w_pat[3];
                end
                OP_CLEAR: begin
                    n_codes = {GLYPH_BLANK, GLYPH_BLANK, GLYPH_BLANK, GLYPH_BLANK};
                end
                OP_NUMBER: begin
                    n_codes = w_num_codes;
                end
                OP_PROGRAM: begin
                    n_codes = {GLYPH_BLANK, GLYPH_P, r_s2_idx, GLYPH_BLANK};
                end
                OP_RUNNING: begin
                    n_codes = {GLYPH_RUN3, GLYPH_RUN2, GLYPH_RUN1, r_s2_idx};
                end
                default: begin
                    // unused operation codes change nothing
                    n_codes = r_codes;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_codes     <= {GLYPH_BLANK, GLYPH_BLANK, GLYPH_BLANK, GLYPH_BLANK};
            r_pos       <= 2'd0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_codes     <= n_codes;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_pos    <= n_out_pos;
            r_out_common <= n_out_common;
            r_out_seg    <= n_out_seg;
            r_out_bottom <= n_out_bottom;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.digit_position = r_out_pos;
    assign o_out.common_drive   = r_out_common;
    assign o_out.segment_drive  = r_out_seg;
    assign o_out.bottom_drive   = r_out_bottom;

endmodule

// ===== design/fdss_checker.sv =====
module fdss_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_pos,
    input logic [3:0] i_common,
    input logic [6:0] i_seg,
    input logic       i_bottom
);

    // a stalled result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_pos) && $stable(i_common)
            && $stable(i_seg) && $stable(i_bottom))
        else $error("result changed while stalled");

    // only the scanned digit's common is driven low
    a_common: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_common == (4'hF & ~(4'b0001 << i_pos))))
        else $error("common drive does not match digit position");

    // back-to-back results come from consecutive ticks
    a_scan_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready) ##1 (i_out_valid && i_out_ready) |->
            i_pos == 2'($past(i_pos) + 2'd1))
        else $error("scan position skipped");

    // input stalls only behind a held result
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("input stalled without a held result");

    // blank digit never lights the bottom bar
    a_blank_bottom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_seg == 7'h7F) |-> i_bottom)
        else $error("bottom bar lit on blank digit");

endmodule

bind four_digit_seven_segment_scanner_top fdss_checker u_fdss_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_pos       (o_out.digit_position),
    .i_common    (o_out.common_drive),
    .i_seg       (o_out.segment_drive),
    .i_bottom    (o_out.bottom_drive)
);
